>>> hw/rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [6:0] SEXTET_BAD = 7'h40;  // flag bit: not in the alphabet

    localparam logic [1:0] ENC_LAST  = 2'd3;    // four characters per group
    localparam logic [1:0] DEC_LAST  = 2'd2;    // three bytes per group

    // one request from the front to the back: a group to be written out
    typedef struct packed {
        logic [23:0] bits;       // left aligned group
        logic        dec;        // 1: bytes out, 0: characters out
        logic [1:0]  data_last;  // index of last character/byte taken from bits
        logic [1:0]  last;       // index of last result, pads included
        logic        eom;        // request closes a message
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] r;
        if (s < 6'd26)
            r = 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            r = 8'h61 + {2'b00, s} - 8'd26;
        else if (s < 6'd62)
            r = 8'h30 + {2'b00, s} - 8'd52;
        else if (s == 6'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

    function automatic logic [6:0] b64_sextet(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A)
            r = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A)
            r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B)
            r = 7'd62;
        else if (c == 8'h2F)
            r = 7'd63;
        else
            r = SEXTET_BAD;
        return r;
    endfunction

endpackage

>>> hw/rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Accepts input items, gathers groups and issues one output request per item
// that causes results.
// ----------------------------------------------------------------------------
module b64_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic          cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          byte_present,
    input  logic          end_of_message,
    input  logic          q_full,
    output logic          push,
    output b64_pkg::job_t job
);
    import b64_pkg::*;

    logic        mode_reg;
    logic [23:0] bits_reg,   bits_next;
    logic [1:0]  cnt_reg,    cnt_next;
    logic        halted_reg, halted_next;
    logic        accept;
    logic [1:0]  cnt_inc;
    logic [6:0]  sx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = cnt_reg + 2'd1;
    assign sx       = b64_sextet(data_byte);

    always_comb
    begin
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        job.bits      = bits_reg;
        job.dec       = mode_reg;
        job.data_last = ENC_LAST;
        job.last      = ENC_LAST;
        job.eom       = end_of_message;

        if (!mode_reg)
        begin
            if (byte_present)
            begin
                case (cnt_reg)
                    2'd0:    bits_next[23:16] = data_byte;
                    2'd1:    bits_next[15:8]  = data_byte;
                    default: bits_next[7:0]   = data_byte;
                endcase
                cnt_next = cnt_inc;
            end
            job.bits = bits_next;
            if (cnt_next == 2'd3)
            begin
                push     = 1'b1;
                cnt_next = 2'd0;
            end
            else if (end_of_message && cnt_next != 2'd0)
            begin
                // partial group: count+1 characters, then pads up to four
                push          = 1'b1;
                job.data_last = cnt_next;
            end
        end
        else
        begin
            if (byte_present && !halted_reg)
            begin
                if (sx[6])
                    halted_next = 1'b1;
                else
                begin
                    case (cnt_reg)
                        2'd0:    bits_next[23:18] = sx[5:0];
                        2'd1:    bits_next[17:12] = sx[5:0];
                        2'd2:    bits_next[11:6]  = sx[5:0];
                        default: bits_next[5:0]   = sx[5:0];
                    endcase
                    cnt_next = cnt_inc;
                end
            end
            job.bits = bits_next;
            if (byte_present && !halted_reg && !sx[6] && cnt_reg == 2'd3)
            begin
                push          = 1'b1;
                job.data_last = DEC_LAST;
                job.last      = DEC_LAST;
            end
            else if (end_of_message && cnt_next[1])
            begin
                // n pending characters give n-1 bytes
                push          = 1'b1;
                job.data_last = cnt_next - 2'd2;
                job.last      = cnt_next - 2'd2;
            end
        end

        if (push || end_of_message)
        begin
            bits_next = '0;
            cnt_next  = 2'd0;
        end
        if (end_of_message)
            halted_next = 1'b0;
        if (!accept)
            push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            bits_reg   <= '0;
            cnt_reg    <= 2'd0;
            halted_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            mode_reg   <= cfg_data;
            bits_reg   <= '0;
            cnt_reg    <= 2'd0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            bits_reg   <= bits_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

endmodule

>>> hw/rtl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module b64_queue #(
    parameter int DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  b64_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output b64_pkg::job_t rd_job
);
    import b64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

>>> hw/rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Walks one request at a time and emits its results through an output
// register, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b64_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  b64_pkg::job_t job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          message_end
);
    import b64_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, end_reg;
    logic       load, is_last;
    logic [5:0] sext;

    assign load    = job_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == job.last);
    assign pop     = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sext = job.bits[23:18];
            2'd1:    sext = job.bits[17:12];
            2'd2:    sext = job.bits[11:6];
            default: sext = job.bits[5:0];
        endcase
        if (job.dec)
        begin
            case (idx_reg)
                2'd0:    byte_next = job.bits[23:16];
                2'd1:    byte_next = job.bits[15:8];
                default: byte_next = job.bits[7:0];
            endcase
        end
        else if (idx_reg > job.data_last)
            byte_next = PAD_CHAR;
        else
            byte_next = b64_char(sext);

        if (!load)
            idx_next = idx_reg;
        else if (is_last)
            idx_next = 2'd0;
        else
            idx_next = idx_reg + 2'd1;

        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= is_last;
            end_reg  <= is_last && job.eom;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign run_last    = last_reg;
    assign message_end = end_reg;

endmodule

>>> hw/rtl/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec
// Streaming Base64 encoder/decoder, standard alphabet, one byte per item.
// ----------------------------------------------------------------------------
// An input item is accepted whenever the request queue (QUEUE_DEPTH entries)
// has room; the output port moves one result per cycle from a registered
// stage while out_ready is high. In encode the output side sets the sustained
// rate, as each full group of three input bytes gives four characters. In
// decode the input side sets it: one character per cycle while the queue has
// room, as four input characters give the three bytes of a group. cfg_data
// selects decode (1) or encode (0); a write also clears any pending group and
// is to be issued only while idle.
module base64_codec #(
    parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       byte_present,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_end
);
    import b64_pkg::*;

    job_t wr_job, rd_job;
    logic push, pop, q_full, q_valid;

    assign cfg_ready = 1'b1;

    b64_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_valid),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .push           (push),
        .job            (wr_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_job   (wr_job),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_job   (rd_job)
    );

    b64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (rd_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .message_end (message_end)
    );

endmodule

>>> hw/rtl/b64_checker.sv
// ----------------------------------------------------------------------------
// b64_checker
// Port-level checks on the codec, attached to the top level by bind.
// ----------------------------------------------------------------------------
module b64_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       message_end
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
        && $stable(run_last) && $stable(message_end))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_last)
        else $error("message_end without run_last");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind base64_codec b64_checker u_b64_checker (.*);

>>> sim/tb_base64_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_codec
// Self-checking bench for the streaming Base64 codec. A short table of
// hand-picked requests in both modes comes first, followed by random
// messages (well-formed text with some noise and broken groups) under
// several sender idle and receiver stall patterns. Typed rows carry their
// own results; all others are checked against a behavioral codec model.
// ----------------------------------------------------------------------------
module tb_base64_codec;

    localparam logic [8*64-1:0] B64_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int DRAIN_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 10;
    localparam int N_DIR           = 25;

    typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

    // typed rows carry their results left aligned in outs
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        present;
        logic        eom;
        logic        typed;
        logic [2:0]  n_out;
        logic [31:0] outs;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } b64_result_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic       cfg_data       = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte      = 8'h00;
    logic       byte_present   = 1'b0;
    logic       end_of_message = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;

    // codec model state
    logic        dec_mode = 1'b0;
    logic [23:0] grp_bits = 24'h0;
    logic [1:0]  grp_cnt  = 2'd0;
    logic        halted   = 1'b0;

    b64_result_t owed_results[$];
    int          mismatches     = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          idle_sched[4]  = '{0, 71, 0, 31};
    int          stall_sched[4] = '{0, 0, 71, 31};
    dir_row_t    dir_tab[N_DIR];

    base64_codec i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .message_end    (message_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        return B64_ALPHA[8*(63 - int'(s)) +: 8];
    endfunction

    // 64 marks a character outside the alphabet
    function automatic int sextet_of(input logic [7:0] c);
        int i;
        for (i = 0; i < 64; i++)
        begin
            if (alpha_char(6'(i)) == c)
                return i;
        end
        return 64;
    endfunction

    function automatic void clear_group();
        grp_bits = 24'h0;
        grp_cnt  = 2'd0;
        halted   = 1'b0;
    endfunction

    // appends one result to the tail of the expected list
    function automatic void owe_result(input b64_result_t r);
        owed_results.insert(owed_results.size(), r);
    endfunction

    // advances the model by one input request; queues its results if keep
    function automatic void base64_step(input logic [7:0] d, input logic p,
                                        input logic e, input bit keep);
        logic [7:0] outs[4];
        int         n;
        int         s;
        int         i;
        n = 0;
        if (!dec_mode)
        begin
            if (p)
            begin
                grp_bits = grp_bits | (24'(d) << (16 - 8 * int'(grp_cnt)));
                grp_cnt  = grp_cnt + 2'd1;
                if (grp_cnt == 2'd3)
                begin
                    for (i = 0; i < 4; i++)
                    begin
                        outs[n] = alpha_char(grp_bits[18 - 6 * i +: 6]);
                        n++;
                    end
                    grp_bits = 24'h0;
                    grp_cnt  = 2'd0;
                end
            end
            if (e && grp_cnt != 2'd0)
            begin
                for (i = 0; i <= int'(grp_cnt); i++)
                begin
                    outs[n] = alpha_char(grp_bits[18 - 6 * i +: 6]);
                    n++;
                end
                for (i = int'(grp_cnt); i < 3; i++)
                begin
                    outs[n] = b64_pkg::PAD_CHAR;
                    n++;
                end
            end
        end
        else
        begin
            if (p && !halted)
            begin
                s = sextet_of(d);
                if (s > 63)
                    halted = 1'b1;
                else
                begin
                    grp_bits = grp_bits | (24'(s) << (18 - 6 * int'(grp_cnt)));
                    if (grp_cnt == 2'd3)
                    begin
                        for (i = 0; i < 3; i++)
                        begin
                            outs[n] = grp_bits[16 - 8 * i +: 8];
                            n++;
                        end
                        grp_bits = 24'h0;
                        grp_cnt  = 2'd0;
                    end
                    else
                        grp_cnt = grp_cnt + 2'd1;
                end
            end
            if (e && grp_cnt >= 2'd2)
            begin
                for (i = 0; i < int'(grp_cnt) - 1; i++)
                begin
                    outs[n] = grp_bits[16 - 8 * i +: 8];
                    n++;
                end
            end
        end
        if (e)
            clear_group();
        if (keep)
        begin
            for (i = 0; i < n; i++)
                owe_result(b64_result_t'{outs[i], i == n - 1, e && i == n - 1});
        end
    endfunction

    // called and returns at a falling edge; valid stays high on return
    task automatic push_item(input logic [7:0] d, input logic p, input logic e,
                             input bit typed, input logic [2:0] n_out,
                             input logic [31:0] outs);
        int i;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= d;
        byte_present   <= p;
        end_of_message <= e;
        do
            @(posedge clk);
        while (!in_ready);
        base64_step(d, p, e, !typed);
        if (typed)
        begin
            for (i = 0; i < int'(n_out); i++)
                owe_result(b64_result_t'{outs[31 - 8 * i -: 8], i == n_out - 1,
                                         e && i == n_out - 1});
        end
        if (p || e)
            items_sent++;
        @(negedge clk);
    endtask

    // mode change only once the codec has gone quiet
    task automatic write_mode(input logic m);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        dec_mode = m;
        clear_group();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic encode_message();
        int len;
        int i;
        bit eom_on_byte;
        len         = $urandom_range(0, 7);
        eom_on_byte = (len != 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(7) == 0)
                push_item(8'($urandom), 1'b0, 1'b0, 1'b0, 3'd0, 32'h0);
            push_item(8'($urandom), 1'b1, eom_on_byte && i == len - 1,
                      1'b0, 3'd0, 32'h0);
        end
        if (!eom_on_byte)
            push_item(8'($urandom), 1'b0, 1'b1, 1'b0, 3'd0, 32'h0);
    endtask

    // mostly valid padded text; in some messages one character may be replaced by a random byte
    task automatic decode_message();
        int         len;
        int         npad;
        int         total;
        int         bad_at;
        int         i;
        bit         eom_on_byte;
        logic [7:0] c;
        len    = $urandom_range(0, 10);
        npad   = (len % 4 == 2) ? 2 : (len % 4 == 3) ? 1 : 0;
        bad_at = -1;
        if ($urandom_range(4) == 0)
        begin
            npad   = $urandom_range(0, 2);
            bad_at = $urandom_range(0, len + npad);
        end
        total       = len + npad;
        eom_on_byte = (total != 0) && ($urandom_range(1) == 1);
        for (i = 0; i < total; i++)
        begin
            c = (i < len) ? alpha_char(6'($urandom)) : b64_pkg::PAD_CHAR;
            if (i == bad_at)
                c = 8'($urandom);
            if ($urandom_range(7) == 0)
                push_item(8'($urandom), 1'b0, 1'b0, 1'b0, 3'd0, 32'h0);
            push_item(c, 1'b1, eom_on_byte && i == total - 1, 1'b0, 3'd0, 32'h0);
        end
        if (!eom_on_byte)
            push_item(8'($urandom), 1'b0, 1'b1, 1'b0, 3'd0, 32'h0);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_out
        b64_result_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result byte %02h last %b end %b",
                             $realtime, out_byte, run_last, message_end);
            end
            else
            begin
                head = owed_results.pop_front();
                if (out_byte !== head.ch || run_last !== head.run_last ||
                    message_end !== head.msg_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected byte %02h last %b end %b, got %02h %b %b",
                                 $realtime, head.ch, head.run_last, head.msg_end,
                                 out_byte, run_last, message_end);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        int ph;
        dir_tab = '{
            '{ROW_ITEM, 8'h4D, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, 8'h61, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, 8'h6E, 1'b1, 1'b0, 1'b1, 3'd4, "TWFu"},
            '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b1, 3'd4, "AAAA"},
            '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 1'b1, 3'd4, "/w=="},
            '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 1'b1, 3'd4, "//8="},
            // end with nothing pending, then a request with neither byte nor end
            '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b1, 3'd0, 32'h0},
            '{ROW_ITEM, 8'h00, 1'b0, 1'b0, 1'b1, 3'd0, 32'h0},
            '{ROW_MODE, 8'h01, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "T",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "W",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "F",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "u",   1'b1, 1'b0, 1'b1, 3'd3, 32'h4D616E00},
            '{ROW_ITEM, "/",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "w",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "=",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "=",   1'b1, 1'b1, 1'b1, 3'd1, 32'hFF000000},
            // a lone character at end yields nothing
            '{ROW_ITEM, "Q",   1'b1, 1'b1, 1'b1, 3'd0, 32'h0},
            // high byte halts; the two characters held are still flushed
            '{ROW_ITEM, "+",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "/",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, 8'h80, 1'b1, 1'b0, 1'b0, 3'd0, 32'h0},
            '{ROW_ITEM, "A",   1'b1, 1'b1, 1'b0, 3'd0, 32'h0}
        };
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < N_DIR; k++)
        begin
            if (dir_tab[k].kind == ROW_MODE)
                write_mode(dir_tab[k].data[0]);
            else
                push_item(dir_tab[k].data, dir_tab[k].present, dir_tab[k].eom,
                          dir_tab[k].typed, dir_tab[k].n_out, dir_tab[k].outs);
        end

        for (ph = 0; ph < 8; ph++)
        begin
            send_idle_pct  = idle_sched[ph / 2];
            recv_stall_pct = stall_sched[ph / 2];
            write_mode(1'(ph % 2));
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE)
            begin
                if (dec_mode)
                    decode_message();
                else
                    encode_message();
            end
        end

        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
